>>> sv/mlk_pkg.sv
`default_nettype none
package mlk_pkg;

  localparam int CODE_W = 8;
  localparam int TIME_W = 16;
  localparam int CNT_W  = 3;
  localparam int SHAPE_W = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [CODE_W-1:0] FIRST_LETTER = 8'h41;
  localparam logic [CODE_W-1:0] LAST_LETTER  = 8'h5A;

  localparam logic [TIME_W-1:0] RESET_DOT_ON   = 16'd100;
  localparam logic [TIME_W-1:0] RESET_DASH_ON  = 16'd300;
  localparam logic [TIME_W-1:0] RESET_ELEM_GAP = 16'd200;
  localparam logic [TIME_W-1:0] RESET_WORD_GAP = 16'd400;

  localparam logic [REG_IDX_W-1:0] REG_DOT_ON   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_DASH_ON  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_ELEM_GAP = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_WORD_GAP = 2'd3;

  localparam logic PIN_SOUND  = 1'b0;
  localparam logic PIN_SILENT = 1'b1;

  // classified character: space, or letter with element count and dash mask
  typedef struct packed {
    logic               is_space;
    logic [CNT_W-1:0]   count;
    logic [SHAPE_W-1:0] shape;
  } desc_t;

  typedef struct packed {
    logic [TIME_W-1:0] dot_on;
    logic [TIME_W-1:0] dash_on;
    logic [TIME_W-1:0] elem_gap;
    logic [TIME_W-1:0] word_gap;
  } cfg_t;

  // bits 6..4 element count, bits 3..0 elements (bit 0 first, 1 = dash)
  function automatic logic [7:0] letter_shape(input logic [4:0] idx);
    logic [7:0] s;
    unique case (idx)
      5'd0:  s = 8'h22;
      5'd1:  s = 8'h41;
      5'd2:  s = 8'h45;
      5'd3:  s = 8'h31;
      5'd4:  s = 8'h10;
      5'd5:  s = 8'h44;
      5'd6:  s = 8'h33;
      5'd7:  s = 8'h40;
      5'd8:  s = 8'h20;
      5'd9:  s = 8'h4E;
      5'd10: s = 8'h35;
      5'd11: s = 8'h42;
      5'd12: s = 8'h23;
      5'd13: s = 8'h21;
      5'd14: s = 8'h37;
      5'd15: s = 8'h46;
      5'd16: s = 8'h4B;
      5'd17: s = 8'h32;
      5'd18: s = 8'h30;
      5'd19: s = 8'h11;
      5'd20: s = 8'h34;
      5'd21: s = 8'h48;
      5'd22: s = 8'h36;
      5'd23: s = 8'h49;
      5'd24: s = 8'h4D;
      5'd25: s = 8'h43;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

>>> sv/mlk_front.sv
`default_nettype none
module mlk_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic                      full,
  input  wire logic [mlk_pkg::CODE_W-1:0] char_code,
  output logic                           push,
  output mlk_pkg::desc_t                 desc
);
  import mlk_pkg::*;

  logic       is_space;
  logic       is_letter;
  logic [7:0] shape_bits;
  logic [CODE_W-1:0] offset;

  assign is_space  = (char_code == SPACE_CODE);
  assign is_letter = (char_code >= FIRST_LETTER) && (char_code <= LAST_LETTER);
  assign offset    = char_code - FIRST_LETTER;

  always_comb begin
    shape_bits    = letter_shape(offset[4:0]);
    desc.is_space = is_space;
    desc.count    = is_space ? CNT_W'(1) : shape_bits[6:4];
    desc.shape    = shape_bits[3:0];
  end

  // uncoded characters are dropped here
  assign push = start && !full && (is_space || is_letter);

  a_push_needs_request: assert property (@(posedge clk) disable iff (rst)
    push |-> start && !full)
    else $error("push without accepted request");
  a_letter_count: assert property (@(posedge clk) disable iff (rst)
    (push && !desc.is_space) |-> (desc.count != 3'd0 && desc.count <= 3'd4))
    else $error("letter with bad element count");
  a_space_shape: assert property (@(posedge clk) disable iff (rst)
    (push && desc.is_space) |-> !is_letter)
    else $error("space and letter at once");

endmodule
`default_nettype wire

>>> sv/mlk_queue.sv
`default_nettype none
module mlk_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  wire mlk_pkg::desc_t push_data,
  input  wire logic     pop,
  output mlk_pkg::desc_t pop_data,
  output logic          full,
  output logic          not_empty
);
  import mlk_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  desc_t             mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_QW-1:0] count;
  logic [PTR_W-1:0]  wr_ptr_next;
  logic [PTR_W-1:0]  rd_ptr_next;
  logic [CNT_QW-1:0] count_next;

  assign full      = (count == CNT_QW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
    end
    if (push && !pop) begin
      count_next = count + CNT_QW'(1);
    end else if (pop && !push) begin
      count_next = count - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !not_empty))
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_QW'(DEPTH))
    else $error("queue count out of range");

endmodule
`default_nettype wire

>>> sv/mlk_back.sv
`default_nettype none
module mlk_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mlk_pkg::cfg_t              cfg,
  input  wire logic                       q_valid,
  input  wire mlk_pkg::desc_t             q_data,
  output logic                            pop,
  output logic                            valid,
  output logic                            pin_level,
  output logic [mlk_pkg::TIME_W-1:0]      duration,
  output logic                            last
);
  import mlk_pkg::*;

  logic   cur_valid;
  desc_t  cur;
  logic [1:0] idx;
  logic   gap;

  logic   cur_valid_next;
  desc_t  cur_next;
  logic [1:0] idx_next;
  logic   gap_next;
  logic   seg_last;
  logic   seg_pin;
  logic [TIME_W-1:0] seg_dur;

  always_comb begin
    seg_last = cur.is_space || (gap && ((CNT_W'(idx) + CNT_W'(1)) == cur.count));
    pop      = q_valid && (!cur_valid || seg_last);
  end

  // next state of the serializer
  always_comb begin
    cur_valid_next = cur_valid;
    cur_next       = cur;
    idx_next       = idx;
    gap_next       = gap;
    priority if (pop) begin
      cur_valid_next = 1'b1;
      cur_next       = q_data;
      idx_next       = '0;
      gap_next       = 1'b0;
    end else if (cur_valid && seg_last) begin
      cur_valid_next = 1'b0;
    end else if (cur_valid && gap) begin
      idx_next = idx + 2'd1;
      gap_next = 1'b0;
    end else if (cur_valid) begin
      gap_next = 1'b1;
    end
  end

  // segment for the current position
  always_comb begin
    priority if (cur.is_space) begin
      seg_pin = PIN_SILENT;
      seg_dur = cfg.word_gap;
    end else if (gap) begin
      seg_pin = PIN_SILENT;
      seg_dur = cfg.elem_gap;
    end else begin
      seg_pin = PIN_SOUND;
      seg_dur = cur.shape[idx] ? cfg.dash_on : cfg.dot_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      valid     <= 1'b0;
      idx       <= '0;
      gap       <= 1'b0;
    end else begin
      cur_valid <= cur_valid_next;
      valid     <= cur_valid;
      idx       <= idx_next;
      gap       <= gap_next;
    end
  end

  always_ff @(posedge clk) begin
    cur       <= cur_next;
    pin_level <= seg_pin;
    duration  <= seg_dur;
    last      <= seg_last;
  end

  a_valid_from_work: assert property (@(posedge clk) disable iff (rst)
    valid |-> $past(cur_valid))
    else $error("result without work in flight");
  a_sound_not_last: assert property (@(posedge clk) disable iff (rst)
    (valid && pin_level == PIN_SOUND) |-> !last)
    else $error("sounding segment marked last");
  a_gap_follows_sound: assert property (@(posedge clk) disable iff (rst)
    (valid && pin_level == PIN_SOUND) |=> (valid && pin_level == PIN_SILENT))
    else $error("sounding segment not followed by gap");
  a_pop_when_free: assert property (@(posedge clk) disable iff (rst)
    pop |-> (!cur_valid || seg_last))
    else $error("pop while character in progress");

endmodule
`default_nettype wire

>>> sv/morse_letter_keyer.sv
// Morse letter keyer. A character is requested by raising start while busy
// is low; only upper-case A to Z and space are sounded, other codes are
// dropped without output. Each key segment appears on pin_level, duration
// and last for exactly one cycle with valid high, one segment per cycle:
// a letter gives two to eight segments (sounding element then silent gap),
// a space one silent segment of the word gap, and last marks a character's
// final segment. A classifier writes requests into a queue of QUEUE_DEPTH
// entries and a serializer drains it; the serializer's one segment per cycle
// sets the sustained rate, and busy rises only when the queue is full. A
// request passes through the queue and the serializer's character register
// before its first segment is registered on the outputs. The receiver cannot
// stall, so results are never held back. Timing registers are written through
// wr_en, wr_index and wr_data and are read at the time each segment is produced.
`default_nettype none
module morse_letter_keyer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [mlk_pkg::CODE_W-1:0]     char_code,
  input  wire logic                           wr_en,
  input  wire logic [mlk_pkg::REG_IDX_W-1:0]  wr_index,
  input  wire logic [mlk_pkg::TIME_W-1:0]     wr_data,
  output logic                                valid,
  output logic                                pin_level,
  output logic [mlk_pkg::TIME_W-1:0]          duration,
  output logic                                last
);
  import mlk_pkg::*;

  cfg_t  cfg;
  desc_t push_desc;
  desc_t pop_desc;
  logic  push;
  logic  pop;
  logic  full;
  logic  not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot_on   <= RESET_DOT_ON;
      cfg.dash_on  <= RESET_DASH_ON;
      cfg.elem_gap <= RESET_ELEM_GAP;
      cfg.word_gap <= RESET_WORD_GAP;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DOT_ON:   cfg.dot_on   <= wr_data;
        REG_DASH_ON:  cfg.dash_on  <= wr_data;
        REG_ELEM_GAP: cfg.elem_gap <= wr_data;
        REG_WORD_GAP: cfg.word_gap <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = full;

  mlk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .full      (full),
    .char_code (char_code),
    .push      (push),
    .desc      (push_desc)
  );

  mlk_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_desc),
    .pop       (pop),
    .pop_data  (pop_desc),
    .full      (full),
    .not_empty (not_empty)
  );

  mlk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (not_empty),
    .q_data    (pop_desc),
    .pop       (pop),
    .valid     (valid),
    .pin_level (pin_level),
    .duration  (duration),
    .last      (last)
  );

endmodule
`default_nettype wire

>>> verif/tb_morse_letter_keyer.sv
`timescale 1ns / 100ps
module tb_morse_letter_keyer;
  import mlk_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_PHASES = 5;
  localparam int CODED_PER_PHASE = 30;

  typedef struct packed {
    logic              pin;
    logic [TIME_W-1:0] dur;
    logic              fin;
  } key_seg_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [CODE_W-1:0] char_code = '0;
  logic              wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [TIME_W-1:0] wr_data = '0;
  logic              valid;
  logic              pin_level;
  logic [TIME_W-1:0] duration;
  logic              last;

  morse_letter_keyer i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .char_code (char_code),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .valid     (valid),
    .pin_level (pin_level),
    .duration  (duration),
    .last      (last)
  );

  always #HALF_PERIOD clk = ~clk;

  // dot and dash patterns, A through Z
  string letter_code [26] = '{".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....",
                              "..", ".---", "-.-", ".-..", "--", "-.", "---", ".--.",
                              "--.-", ".-.", "...", "-", "..-", "...-", ".--", "-..-",
                              "-.--", "--.."};

  logic [TIME_W-1:0] dot_time  = RESET_DOT_ON;
  logic [TIME_W-1:0] dash_time = RESET_DASH_ON;
  logic [TIME_W-1:0] gap_time  = RESET_ELEM_GAP;
  logic [TIME_W-1:0] word_time = RESET_WORD_GAP;

  key_seg_t expected_segs [$];
  int errors = 0;
  int chars_sent = 0;
  int segs_seen = 0;
  int timing_sets = 0;
  int idle_cycles = 0;
  logic no_idle = 1'b0;

  function automatic key_seg_t make_seg(input logic pin, input logic [TIME_W-1:0] dur,
                                        input logic fin);
    key_seg_t s;
    s.pin = pin;
    s.dur = dur;
    s.fin = fin;
    return s;
  endfunction

  function automatic logic is_coded(input logic [CODE_W-1:0] code);
    return (code == SPACE_CODE) || (code >= FIRST_LETTER && code <= LAST_LETTER);
  endfunction

  function automatic void predict_segments(input logic [CODE_W-1:0] code);
    string shape;
    if (code == SPACE_CODE) begin
      expected_segs.push_back(make_seg(PIN_SILENT, word_time, 1'b1));
    end else if (code >= FIRST_LETTER && code <= LAST_LETTER) begin
      shape = letter_code[code - FIRST_LETTER];
      for (int i = 0; i < shape.len(); i++) begin
        expected_segs.push_back(make_seg(PIN_SOUND, (shape[i] == "-") ? dash_time : dot_time,
                                         1'b0));
        expected_segs.push_back(make_seg(PIN_SILENT, gap_time, i == shape.len() - 1));
      end
    end
  endfunction

  function automatic logic [TIME_W-1:0] pick_time();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return 16'd1;
      2: return 16'hFFFF;
      default: return TIME_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return FIRST_LETTER + CODE_W'($urandom_range(0, 25));
    if (r < 80) return SPACE_CODE;
    return CODE_W'($urandom_range(0, 255));
  endfunction

  // checker: every segment against the oldest expectation
  always @(posedge clk) begin
    key_seg_t want;
    if (!rst && valid === 1'b1) begin
      if (expected_segs.size() == 0) begin
        $display("%0t: unexpected segment, expected none, actual pin_level=%0b duration=%0d last=%0b",
                 $time, pin_level, duration, last);
        errors++;
      end else begin
        want = expected_segs.pop_front();
        segs_seen++;
        if (pin_level !== want.pin) begin
          $display("%0t: pin_level mismatch, expected %0b, actual %0b", $time, want.pin, pin_level);
          errors++;
        end
        if (duration !== want.dur) begin
          $display("%0t: duration mismatch, expected %0d, actual %0d", $time, want.dur, duration);
          errors++;
        end
        if (last !== want.fin) begin
          $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.fin, last);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any request or segment
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no request or segment for %0d cycles", $time, STALL_LIMIT);
      $display("tb_morse_letter_keyer: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_char(input logic [CODE_W-1:0] code);
    int gap;
    if ($urandom_range(0, 24) == 0) no_idle = ~no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    char_code <= code;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_segments(code);
    chars_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
    // uncoded requests are dropped by the classifier and never reach the queue
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [TIME_W-1:0] val);
    @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    @(negedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_DOT_ON:   dot_time = val;
      REG_DASH_ON:  dash_time = val;
      REG_ELEM_GAP: gap_time = val;
      REG_WORD_GAP: word_time = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [TIME_W-1:0] dot, input logic [TIME_W-1:0] dash,
                            input logic [TIME_W-1:0] gap, input logic [TIME_W-1:0] word);
    wait_idle();
    write_reg(REG_DOT_ON, dot);
    write_reg(REG_DASH_ON, dash);
    write_reg(REG_ELEM_GAP, gap);
    write_reg(REG_WORD_GAP, word);
    timing_sets++;
  endtask

  task automatic test_reset_timing();
    send_char(SPACE_CODE);
    send_char("E");
    send_char("T");
    send_char("Q");
  endtask

  task automatic test_char_codes();
    send_char("A");
    send_char(8'h00);
    send_char("Z");
    send_char(8'hFF);
    send_char("H");
    send_char(8'h40);
    send_char("J");
    send_char(8'h5B);
    send_char("O");
    send_char(8'h61);
    send_char(8'h7A);
    send_char(8'h1F);
    send_char(8'h21);
    send_char(SPACE_CODE);
  endtask

  task automatic test_extreme_timing();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_char("Q");
    send_char(SPACE_CODE);
    // zero is kept and still emitted
    set_timing('0, '0, '0, '0);
    send_char("Q");
    send_char(SPACE_CODE);
    set_timing(16'd1, 16'hFFFF, '0, 16'd1);
    send_char("K");
  endtask

  task automatic test_random_text();
    int coded;
    logic [CODE_W-1:0] c;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      set_timing(pick_time(), pick_time(), pick_time(), pick_time());
      coded = 0;
      while (coded < CODED_PER_PHASE) begin
        c = random_char();
        send_char(c);
        if (is_coded(c)) coded++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_timing();
    test_char_codes();
    test_extreme_timing();
    test_random_text();
    wait_idle();
    $display("sent %0d characters, checked %0d key segments", chars_sent, segs_seen);
    $display("over %0d timing settings besides reset, zero and full-scale included", timing_sets);
    if (errors == 0) begin
      $display("tb_morse_letter_keyer: PASS");
    end else begin
      $display("tb_morse_letter_keyer: FAIL");
    end
    $finish;
  end

endmodule
